[src/cfp_pkg.sv]
// Shared types, codes and lookup functions for the class file constant pool parser.
package cfp_pkg;

	localparam logic [2:0] SEC_MAGIC   = 3'd0;
	localparam logic [2:0] SEC_MINOR   = 3'd1;
	localparam logic [2:0] SEC_MAJOR   = 3'd2;
	localparam logic [2:0] SEC_COUNT   = 3'd3;
	localparam logic [2:0] SEC_TAG     = 3'd4;
	localparam logic [2:0] SEC_PAYLOAD = 3'd5;
	localparam logic [2:0] SEC_AFTER   = 3'd6;
	localparam logic [2:0] SEC_ERROR   = 3'd7;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ERR_BAD_TAG   = 2'd2;

	localparam logic [7:0] TAG_UTF8           = 8'd1;
	localparam logic [7:0] TAG_INTEGER        = 8'd3;
	localparam logic [7:0] TAG_FLOAT          = 8'd4;
	localparam logic [7:0] TAG_LONG           = 8'd5;
	localparam logic [7:0] TAG_DOUBLE         = 8'd6;
	localparam logic [7:0] TAG_CLASS          = 8'd7;
	localparam logic [7:0] TAG_STRING         = 8'd8;
	localparam logic [7:0] TAG_FIELDREF       = 8'd9;
	localparam logic [7:0] TAG_METHODREF      = 8'd10;
	localparam logic [7:0] TAG_IFACE_METHREF  = 8'd11;
	localparam logic [7:0] TAG_NAME_AND_TYPE  = 8'd12;
	localparam logic [7:0] TAG_METHOD_HANDLE  = 8'd15;
	localparam logic [7:0] TAG_METHOD_TYPE    = 8'd16;
	localparam logic [7:0] TAG_INVOKE_DYNAMIC = 8'd18;

	typedef enum logic [7:0] {
		PH_MAGIC   = 8'b0000_0001,
		PH_MINOR   = 8'b0000_0010,
		PH_MAJOR   = 8'b0000_0100,
		PH_COUNT   = 8'b0000_1000,
		PH_TAG     = 8'b0001_0000,
		PH_PAYLOAD = 8'b0010_0000,
		PH_AFTER   = 8'b0100_0000,
		PH_ERROR   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  hdr_cnt;
		logic [15:0] count;
		logic [15:0] slot;
		logic [7:0]  tag;
		logic [16:0] remain;
		logic [16:0] offset;
		logic [15:0] minor;
		logic [15:0] major;
		logic [1:0]  err;
	} state_t;

	typedef struct packed {
		logic [2:0]  section;
		logic [7:0]  echo_byte;
		logic [15:0] entry_slot;
		logic [7:0]  entry_tag;
		logic [16:0] payload_offset;
		logic        entry_last;
		logic        pool_done;
		logic [1:0]  error_code;
		logic [15:0] minor_version;
		logic [15:0] major_version;
		logic [15:0] pool_count;
	} result_t;

	localparam state_t STATE_RESET = '{
		phase:   PH_MAGIC,
		hdr_cnt: 3'd0,
		count:   16'd0,
		slot:    16'd1,
		tag:     8'd0,
		remain:  17'd0,
		offset:  17'd0,
		minor:   16'd0,
		major:   16'd0,
		err:     ERR_NONE
	};

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0:    m = 8'hCA;
			2'd1:    m = 8'hFE;
			2'd2:    m = 8'hBA;
			default: m = 8'hBE;
		endcase
		return m;
	endfunction

	// fixed payload length; zero for an unknown tag, two for the Utf8 length field
	function automatic logic [3:0] tag_len(input logic [7:0] t);
		logic [3:0] n;
		case (t)
			TAG_UTF8:                            n = 4'd2;
			TAG_INTEGER, TAG_FLOAT:              n = 4'd4;
			TAG_LONG, TAG_DOUBLE:                n = 4'd8;
			TAG_CLASS, TAG_STRING,
			TAG_METHOD_TYPE:                     n = 4'd2;
			TAG_FIELDREF, TAG_METHODREF,
			TAG_IFACE_METHREF, TAG_NAME_AND_TYPE,
			TAG_INVOKE_DYNAMIC:                  n = 4'd4;
			TAG_METHOD_HANDLE:                   n = 4'd3;
			default:                             n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

[src/cfp_in_if.sv]
// Byte input channel: valid/ready handshake with one class file byte per beat.
interface cfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;

	modport source(output valid, data_byte, start_of_file, input ready);
	modport sink(input valid, data_byte, start_of_file, output ready);
endinterface

[src/cfp_out_if.sv]
// Result channel: valid/ready handshake with one byte classification per beat.
interface cfp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  section;
	logic [7:0]  echo_byte;
	logic [15:0] entry_slot;
	logic [7:0]  entry_tag;
	logic [16:0] payload_offset;
	logic        entry_last;
	logic        pool_done;
	logic [1:0]  error_code;
	logic [15:0] minor_version;
	logic [15:0] major_version;
	logic [15:0] pool_count;

	modport source(output valid, section, echo_byte, entry_slot, entry_tag, payload_offset,
		entry_last, pool_done, error_code, minor_version, major_version, pool_count,
		input ready);
	modport sink(input valid, section, echo_byte, entry_slot, entry_tag, payload_offset,
		entry_last, pool_done, error_code, minor_version, major_version, pool_count,
		output ready);
endinterface

[src/cfp_step.sv]
// Per-byte parse step: next parser state and the classification of one byte.
module cfp_step (
	input  cfp_pkg::state_t  cur,
	input  logic [7:0]       data_byte,
	input  logic             start_of_file,
	output cfp_pkg::state_t  nxt,
	output cfp_pkg::result_t res
);

	cfp_pkg::state_t st;
	logic [15:0]     count_new;
	logic [3:0]      len;
	logic            utf8;
	logic            long_tag;
	logic [16:0]     rem_new;
	logic            last;
	logic [16:0]     next_slot;

	assign st        = start_of_file ? cfp_pkg::STATE_RESET : cur;
	assign count_new = {st.count[7:0], data_byte};
	assign len       = cfp_pkg::tag_len(data_byte);
	assign utf8      = (st.tag == cfp_pkg::TAG_UTF8);
	assign long_tag  = (st.tag == cfp_pkg::TAG_LONG) || (st.tag == cfp_pkg::TAG_DOUBLE);
	assign next_slot = {1'b0, st.slot} + (long_tag ? 17'd2 : 17'd1);

	always_comb begin
		if (utf8 && st.offset == 17'd0) begin
			rem_new = {1'b0, data_byte, 8'h00};
			last    = 1'b0;
		end else if (utf8 && st.offset == 17'd1) begin
			rem_new = {1'b0, st.remain[15:8], st.remain[7:0] | data_byte};
			last    = (rem_new == 17'd0);
		end else begin
			rem_new = (st.remain != 17'd0) ? st.remain - 17'd1 : st.remain;
			last    = (rem_new == 17'd0);
		end
	end

	always_comb begin
		nxt                = st;
		res.section        = cfp_pkg::SEC_ERROR;
		res.echo_byte      = data_byte;
		res.entry_slot     = 16'd0;
		res.entry_tag      = 8'd0;
		res.payload_offset = 17'd0;
		res.entry_last     = 1'b0;
		res.pool_done      = 1'b0;
		case (st.phase)
			cfp_pkg::PH_MAGIC: begin
				if (data_byte != cfp_pkg::magic_byte(st.hdr_cnt[1:0])) begin
					nxt.err   = cfp_pkg::ERR_BAD_MAGIC;
					nxt.phase = cfp_pkg::PH_ERROR;
				end else begin
					res.section = cfp_pkg::SEC_MAGIC;
					if (st.hdr_cnt[1:0] == 2'd3) begin
						nxt.hdr_cnt = 3'd0;
						nxt.phase   = cfp_pkg::PH_MINOR;
					end else begin
						nxt.hdr_cnt = st.hdr_cnt + 3'd1;
					end
				end
			end
			cfp_pkg::PH_MINOR: begin
				res.section = cfp_pkg::SEC_MINOR;
				nxt.minor   = {st.minor[7:0], data_byte};
				if (st.hdr_cnt[0]) begin
					nxt.hdr_cnt = 3'd0;
					nxt.phase   = cfp_pkg::PH_MAJOR;
				end else begin
					nxt.hdr_cnt = st.hdr_cnt + 3'd1;
				end
			end
			cfp_pkg::PH_MAJOR: begin
				res.section = cfp_pkg::SEC_MAJOR;
				nxt.major   = {st.major[7:0], data_byte};
				if (st.hdr_cnt[0]) begin
					nxt.hdr_cnt = 3'd0;
					nxt.phase   = cfp_pkg::PH_COUNT;
				end else begin
					nxt.hdr_cnt = st.hdr_cnt + 3'd1;
				end
			end
			cfp_pkg::PH_COUNT: begin
				res.section = cfp_pkg::SEC_COUNT;
				nxt.count   = count_new;
				if (st.hdr_cnt[0]) begin
					nxt.hdr_cnt = 3'd0;
					nxt.slot    = 16'd1;
					if (count_new <= 16'd1) begin
						nxt.phase     = cfp_pkg::PH_AFTER;
						res.pool_done = 1'b1;
					end else begin
						nxt.phase = cfp_pkg::PH_TAG;
					end
				end else begin
					nxt.hdr_cnt = st.hdr_cnt + 3'd1;
				end
			end
			cfp_pkg::PH_TAG: begin
				if (len == 4'd0) begin
					nxt.err   = cfp_pkg::ERR_BAD_TAG;
					nxt.phase = cfp_pkg::PH_ERROR;
				end else begin
					res.section    = cfp_pkg::SEC_TAG;
					res.entry_slot = st.slot;
					res.entry_tag  = data_byte;
					nxt.tag        = data_byte;
					nxt.remain     = 17'(len);
					nxt.offset     = 17'd0;
					nxt.phase      = cfp_pkg::PH_PAYLOAD;
				end
			end
			cfp_pkg::PH_PAYLOAD: begin
				res.section        = cfp_pkg::SEC_PAYLOAD;
				res.entry_slot     = st.slot;
				res.entry_tag      = st.tag;
				res.payload_offset = st.offset;
				res.entry_last     = last;
				nxt.remain         = rem_new;
				nxt.offset         = st.offset + 17'd1;
				if (last) begin
					if (next_slot >= {1'b0, st.count}) begin
						nxt.phase     = cfp_pkg::PH_AFTER;
						res.pool_done = 1'b1;
					end else begin
						nxt.slot  = next_slot[15:0];
						nxt.phase = cfp_pkg::PH_TAG;
					end
				end
			end
			cfp_pkg::PH_AFTER: begin
				res.section   = cfp_pkg::SEC_AFTER;
				res.pool_done = 1'b1;
			end
			default: begin
				res.section = cfp_pkg::SEC_ERROR;
			end
		endcase
		res.error_code    = nxt.err;
		res.minor_version = nxt.minor;
		res.major_version = nxt.major;
		res.pool_count    = nxt.count;
	end

endmodule

[src/class_file_constant_pool_parser.sv]
// Top level of the class file constant pool parser.
//
// Usage: class file bytes enter on the bytes channel, one per beat, with
// start_of_file set on the first byte of each file. Every byte gives exactly
// one beat on the results channel that classifies it (section, slot, tag,
// payload offset, entry end, pool done, sticky error) and shows the captured
// minor version, major version and constant pool count.
// A byte accepted into the input register is classified by the step, and its
// result is registered in the result register when the receiver is not stalled.
// Throughput: one byte per cycle unless the receiver stalls; the parse state
// advances once per byte through a combinational step between the registers.
// Reset (arst_n low) clears the parse state to the start of the magic field,
// so a file may start without start_of_file after reset.
// When the receiver stalls, the result is held and one further byte is taken
// into the input register; bytes.ready then drops until results move on.
module class_file_constant_pool_parser (
	input logic        clk,
	input logic        arst_n,
	cfp_in_if.sink     bytes,
	cfp_out_if.source  results
);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             sof_s1;
	logic             res_valid_q;
	cfp_pkg::result_t res_q;
	cfp_pkg::state_t  state_q;
	cfp_pkg::state_t  state_nxt;
	cfp_pkg::result_t res_nxt;
	logic             advance;

	assign advance     = valid_s1 && (!res_valid_q || results.ready);
	assign bytes.ready = !valid_s1 || advance;

	cfp_step u_step (
		.cur           (state_q),
		.data_byte     (data_s1),
		.start_of_file (sof_s1),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= cfp_pkg::STATE_RESET;
		end else begin
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1 <= bytes.data_byte;
			sof_s1  <= bytes.start_of_file;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign results.valid          = res_valid_q;
	assign results.section        = res_q.section;
	assign results.echo_byte      = res_q.echo_byte;
	assign results.entry_slot     = res_q.entry_slot;
	assign results.entry_tag      = res_q.entry_tag;
	assign results.payload_offset = res_q.payload_offset;
	assign results.entry_last     = res_q.entry_last;
	assign results.pool_done      = res_q.pool_done;
	assign results.error_code     = res_q.error_code;
	assign results.minor_version  = res_q.minor_version;
	assign results.major_version  = res_q.major_version;
	assign results.pool_count     = res_q.pool_count;

endmodule

[src/cfp_checker.sv]
// Port-level assertions for the class file constant pool parser, bound to the top level.
module cfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  section,
	input logic [7:0]  echo_byte,
	input logic        entry_last,
	input logic        pool_done,
	input logic [1:0]  error_code
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(echo_byte) && $stable(section))
		else $error("result beat changed while stalled");

	a_error_section: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((section == cfp_pkg::SEC_ERROR) == (error_code != cfp_pkg::ERR_NONE)))
		else $error("error section and error code disagree");

	a_last_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_last |-> section == cfp_pkg::SEC_PAYLOAD)
		else $error("entry end outside payload");

	// the pool completes on the last count byte, on the last payload byte, or is already done
	a_done_after_pool: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pool_done |-> (section == cfp_pkg::SEC_COUNT
			|| section == cfp_pkg::SEC_PAYLOAD || section == cfp_pkg::SEC_AFTER))
		else $error("pool done outside pool end or after-pool section");

endmodule

bind class_file_constant_pool_parser cfp_checker u_cfp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.section    (results.section),
	.echo_byte  (results.echo_byte),
	.entry_last (results.entry_last),
	.pool_done  (results.pool_done),
	.error_code (results.error_code)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the class file constant pool parser: directed table, random files.
module testbench;

	localparam int CLK_PERIOD       = 4;
	localparam int RESET_CYCLES     = 10;
	localparam int RANDOM_PER_PHASE = 584;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES     = 16;
	localparam int CYCLE_LIMIT      = 200000;
	localparam logic [31:0] MAGIC_WORD = 32'hCAFE_BABE;

	localparam logic [7:0] KNOWN_TAGS [14] = '{
		cfp_pkg::TAG_UTF8, cfp_pkg::TAG_INTEGER, cfp_pkg::TAG_FLOAT, cfp_pkg::TAG_LONG,
		cfp_pkg::TAG_DOUBLE, cfp_pkg::TAG_CLASS, cfp_pkg::TAG_STRING, cfp_pkg::TAG_FIELDREF,
		cfp_pkg::TAG_METHODREF, cfp_pkg::TAG_IFACE_METHREF, cfp_pkg::TAG_NAME_AND_TYPE,
		cfp_pkg::TAG_METHOD_HANDLE, cfp_pkg::TAG_METHOD_TYPE, cfp_pkg::TAG_INVOKE_DYNAMIC
	};

	// one byte to send; typed rows carry a hand-written expectation
	typedef struct packed {
		logic [7:0]  data;
		logic        sof;
		logic        typed;
		logic [2:0]  sec;
		logic [1:0]  err;
		logic        done;
		logic [15:0] minor;
		logic [15:0] major;
		logic [15:0] count;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;

	cfp_in_if  bytes_ch();
	cfp_out_if results_ch();

	class_file_constant_pool_parser i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_ch),
		.results (results_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	stim_t            pending_bytes [$];
	cfp_pkg::result_t predicted_results [$];
	int               beats_queued;
	int               mismatch_count;
	int               cycle_count;
	int               src_idle_pct;
	int               sink_idle_pct;
	logic             pressure_go;
	logic             long_hold;

	// parser shadow state
	cfp_pkg::phase_t parse_phase;
	int              header_pos;
	logic [15:0]     count_field;
	logic [15:0]     slot_no;
	logic [7:0]      entry_type;
	logic [16:0]     remaining;
	logic [16:0]     offset_pos;
	logic [15:0]     minor_field;
	logic [15:0]     major_field;
	logic [1:0]      sticky_err;

	stim_t directed_rows [25] = '{
		// after reset, no start flag: minor at its extreme, unknown tag 0x00
		'{8'hCA, 1'b0, 1'b1, cfp_pkg::SEC_MAGIC, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'hFE, 1'b0, 1'b1, cfp_pkg::SEC_MAGIC, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'hBA, 1'b0, 1'b1, cfp_pkg::SEC_MAGIC, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'hBE, 1'b0, 1'b1, cfp_pkg::SEC_MAGIC, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'hFF, 1'b0, 1'b1, cfp_pkg::SEC_MINOR, cfp_pkg::ERR_NONE, 1'b0, 16'h00FF, 16'h0, 16'h0},
		'{8'hFF, 1'b0, 1'b1, cfp_pkg::SEC_MINOR, cfp_pkg::ERR_NONE, 1'b0, 16'hFFFF, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b0, cfp_pkg::SEC_MAJOR, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b0, cfp_pkg::SEC_MAJOR, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b0, cfp_pkg::SEC_COUNT, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h02, 1'b0, 1'b0, cfp_pkg::SEC_COUNT, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b1, cfp_pkg::SEC_ERROR, cfp_pkg::ERR_BAD_TAG, 1'b0,
			16'hFFFF, 16'h0, 16'h0002},
		'{8'hFF, 1'b0, 1'b1, cfp_pkg::SEC_ERROR, cfp_pkg::ERR_BAD_TAG, 1'b0,
			16'hFFFF, 16'h0, 16'h0002},
		// restart clears the error, then bad magic; error holds on a matching byte
		'{8'hCA, 1'b1, 1'b1, cfp_pkg::SEC_MAGIC, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b1, cfp_pkg::SEC_ERROR, cfp_pkg::ERR_BAD_MAGIC, 1'b0,
			16'h0, 16'h0, 16'h0},
		'{8'hBE, 1'b0, 1'b1, cfp_pkg::SEC_ERROR, cfp_pkg::ERR_BAD_MAGIC, 1'b0,
			16'h0, 16'h0, 16'h0},
		// empty pool
		'{8'hCA, 1'b1, 1'b0, cfp_pkg::SEC_MAGIC, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'hFE, 1'b0, 1'b0, cfp_pkg::SEC_MAGIC, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'hBA, 1'b0, 1'b0, cfp_pkg::SEC_MAGIC, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'hBE, 1'b0, 1'b0, cfp_pkg::SEC_MAGIC, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b0, cfp_pkg::SEC_MINOR, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b0, cfp_pkg::SEC_MINOR, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b0, cfp_pkg::SEC_MAJOR, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b0, cfp_pkg::SEC_MAJOR, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h00, 1'b0, 1'b0, cfp_pkg::SEC_COUNT, cfp_pkg::ERR_NONE, 1'b0, 16'h0, 16'h0, 16'h0},
		'{8'h01, 1'b0, 1'b1, cfp_pkg::SEC_COUNT, cfp_pkg::ERR_NONE, 1'b1, 16'h0, 16'h0, 16'h0001}
	};

	function automatic logic [16:0] payload_length(input logic [7:0] t);
		logic [16:0] n;
		case (t)
			cfp_pkg::TAG_UTF8:                                 n = 17'd2;
			cfp_pkg::TAG_INTEGER, cfp_pkg::TAG_FLOAT:          n = 17'd4;
			cfp_pkg::TAG_LONG, cfp_pkg::TAG_DOUBLE:            n = 17'd8;
			cfp_pkg::TAG_CLASS, cfp_pkg::TAG_STRING,
			cfp_pkg::TAG_METHOD_TYPE:                          n = 17'd2;
			cfp_pkg::TAG_FIELDREF, cfp_pkg::TAG_METHODREF,
			cfp_pkg::TAG_IFACE_METHREF, cfp_pkg::TAG_NAME_AND_TYPE,
			cfp_pkg::TAG_INVOKE_DYNAMIC:                       n = 17'd4;
			cfp_pkg::TAG_METHOD_HANDLE:                        n = 17'd3;
			default:                                           n = 17'd0;
		endcase
		return n;
	endfunction

	function automatic void clear_parser();
		parse_phase = cfp_pkg::PH_MAGIC;
		header_pos  = 0;
		count_field = '0;
		slot_no     = 16'd1;
		entry_type  = '0;
		remaining   = '0;
		offset_pos  = '0;
		minor_field = '0;
		major_field = '0;
		sticky_err  = cfp_pkg::ERR_NONE;
	endfunction

	function automatic cfp_pkg::result_t classify_byte(input logic [7:0] b, input logic sof);
		cfp_pkg::result_t r;
		logic [16:0]      len;
		int               next_slot;
		r = '0;
		r.section   = cfp_pkg::SEC_ERROR;
		r.echo_byte = b;
		if (sof)
			clear_parser();
		case (parse_phase)
			cfp_pkg::PH_MAGIC: begin
				if (b != MAGIC_WORD[8 * (3 - header_pos) +: 8]) begin
					sticky_err  = cfp_pkg::ERR_BAD_MAGIC;
					parse_phase = cfp_pkg::PH_ERROR;
				end else begin
					r.section = cfp_pkg::SEC_MAGIC;
					header_pos++;
					if (header_pos == 4) begin
						header_pos  = 0;
						parse_phase = cfp_pkg::PH_MINOR;
					end
				end
			end
			cfp_pkg::PH_MINOR: begin
				r.section   = cfp_pkg::SEC_MINOR;
				minor_field = {minor_field[7:0], b};
				header_pos++;
				if (header_pos == 2) begin
					header_pos  = 0;
					parse_phase = cfp_pkg::PH_MAJOR;
				end
			end
			cfp_pkg::PH_MAJOR: begin
				r.section   = cfp_pkg::SEC_MAJOR;
				major_field = {major_field[7:0], b};
				header_pos++;
				if (header_pos == 2) begin
					header_pos  = 0;
					parse_phase = cfp_pkg::PH_COUNT;
				end
			end
			cfp_pkg::PH_COUNT: begin
				r.section   = cfp_pkg::SEC_COUNT;
				count_field = {count_field[7:0], b};
				header_pos++;
				if (header_pos == 2) begin
					header_pos = 0;
					slot_no    = 16'd1;
					if (count_field <= 16'd1) begin
						parse_phase = cfp_pkg::PH_AFTER;
						r.pool_done = 1'b1;
					end else begin
						parse_phase = cfp_pkg::PH_TAG;
					end
				end
			end
			cfp_pkg::PH_TAG: begin
				len = payload_length(b);
				if (len == '0) begin
					sticky_err  = cfp_pkg::ERR_BAD_TAG;
					parse_phase = cfp_pkg::PH_ERROR;
				end else begin
					r.section    = cfp_pkg::SEC_TAG;
					r.entry_slot = slot_no;
					r.entry_tag  = b;
					entry_type   = b;
					remaining    = len;
					offset_pos   = '0;
					parse_phase  = cfp_pkg::PH_PAYLOAD;
				end
			end
			cfp_pkg::PH_PAYLOAD: begin
				r.section        = cfp_pkg::SEC_PAYLOAD;
				r.entry_slot     = slot_no;
				r.entry_tag      = entry_type;
				r.payload_offset = offset_pos;
				if (entry_type == cfp_pkg::TAG_UTF8 && offset_pos == 17'd0) begin
					remaining = {1'b0, b, 8'h00};
				end else if (entry_type == cfp_pkg::TAG_UTF8 && offset_pos == 17'd1) begin
					remaining    = {1'b0, remaining[15:8], b};
					r.entry_last = (remaining == '0);
				end else begin
					if (remaining != '0)
						remaining--;
					r.entry_last = (remaining == '0);
				end
				offset_pos = offset_pos + 17'd1;
				if (r.entry_last) begin
					next_slot = int'(slot_no) + ((entry_type == cfp_pkg::TAG_LONG
						|| entry_type == cfp_pkg::TAG_DOUBLE) ? 2 : 1);
					if (next_slot >= int'(count_field)) begin
						parse_phase = cfp_pkg::PH_AFTER;
						r.pool_done = 1'b1;
					end else begin
						slot_no     = next_slot[15:0];
						parse_phase = cfp_pkg::PH_TAG;
					end
				end
			end
			cfp_pkg::PH_AFTER: begin
				r.section   = cfp_pkg::SEC_AFTER;
				r.pool_done = 1'b1;
			end
			default: ;
		endcase
		r.error_code    = sticky_err;
		r.minor_version = minor_field;
		r.major_version = major_field;
		r.pool_count    = count_field;
		return r;
	endfunction

	task automatic add_beat(input logic [7:0] b, input logic sof);
		stim_t s;
		s      = '0;
		s.data = b;
		s.sof  = sof;
		pending_bytes = {pending_bytes, s};
		beats_queued++;
	endtask

	// mostly well-formed files; some with bad magic, unknown tags, cut short, or stray bytes
	task automatic queue_random_file();
		int          kind, mangle, pick, count, slots_left, k;
		logic [15:0] len;
		logic [7:0]  t;
		kind = $urandom_range(99);
		if (kind < 12) begin
			k = $urandom_range(3);
			for (int i = 0; i < k; i++)
				add_beat(MAGIC_WORD[8 * (3 - i) +: 8], i == 0);
			do t = 8'($urandom_range(255)); while (t == MAGIC_WORD[8 * (3 - k) +: 8]);
			add_beat(t, k == 0);
			repeat ($urandom_range(4)) add_beat(8'($urandom_range(255)), 1'b0);
		end else if (kind < 18) begin
			repeat ($urandom_range(1, 6)) add_beat(8'($urandom_range(255)), 1'b0);
		end else begin
			mangle = $urandom_range(99);
			pick   = $urandom_range(99);
			if (pick < 10)
				count = $urandom_range(1);
			else if (pick < 93)
				count = $urandom_range(2, 12);
			else if (pick < 98)
				count = $urandom_range(13, 40);
			else begin
				count  = $urandom_range(65535);
				mangle = 10;
			end
			for (int i = 0; i < 4; i++)
				add_beat(MAGIC_WORD[8 * (3 - i) +: 8], i == 0);
			repeat (4) add_beat(8'($urandom_range(255)), 1'b0);
			add_beat(count[15:8], 1'b0);
			add_beat(count[7:0], 1'b0);
			slots_left = (count > 1) ? count - 1 : 0;
			while (slots_left > 0) begin
				if (mangle < 8 && $urandom_range(3) == 0) begin
					do t = 8'($urandom_range(255)); while (payload_length(t) != '0);
					add_beat(t, 1'b0);
					slots_left = 0;
				end else if (mangle < 14 && $urandom_range(2) == 0) begin
					slots_left = 0;
				end else begin
					t = KNOWN_TAGS[$urandom_range(13)];
					add_beat(t, 1'b0);
					if (t == cfp_pkg::TAG_UTF8) begin
						pick = $urandom_range(99);
						if (pick < 50)
							len = 16'($urandom_range(3));
						else if (pick < 92)
							len = 16'($urandom_range(4, 16));
						else
							len = 16'($urandom_range(200, 300));
						add_beat(len[15:8], 1'b0);
						add_beat(len[7:0], 1'b0);
						repeat (len) add_beat(8'($urandom_range(255)), 1'b0);
					end else begin
						repeat (payload_length(t)) add_beat(8'($urandom_range(255)), 1'b0);
					end
					slots_left -= (t == cfp_pkg::TAG_LONG || t == cfp_pkg::TAG_DOUBLE) ? 2 : 1;
				end
			end
			if (mangle >= 8)
				repeat ($urandom_range(3)) add_beat(8'($urandom_range(255)), 1'b0);
		end
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatch_count < 100)
			$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
		mismatch_count++;
	endtask

	task automatic compare_result(input cfp_pkg::result_t want);
		if (results_ch.section !== want.section)
			note_mismatch("section", 32'(results_ch.section), 32'(want.section));
		if (results_ch.echo_byte !== want.echo_byte)
			note_mismatch("echo_byte", 32'(results_ch.echo_byte), 32'(want.echo_byte));
		if (results_ch.entry_slot !== want.entry_slot)
			note_mismatch("entry_slot", 32'(results_ch.entry_slot), 32'(want.entry_slot));
		if (results_ch.entry_tag !== want.entry_tag)
			note_mismatch("entry_tag", 32'(results_ch.entry_tag), 32'(want.entry_tag));
		if (results_ch.payload_offset !== want.payload_offset)
			note_mismatch("payload_offset", 32'(results_ch.payload_offset),
				32'(want.payload_offset));
		if (results_ch.entry_last !== want.entry_last)
			note_mismatch("entry_last", 32'(results_ch.entry_last), 32'(want.entry_last));
		if (results_ch.pool_done !== want.pool_done)
			note_mismatch("pool_done", 32'(results_ch.pool_done), 32'(want.pool_done));
		if (results_ch.error_code !== want.error_code)
			note_mismatch("error_code", 32'(results_ch.error_code), 32'(want.error_code));
		if (results_ch.minor_version !== want.minor_version)
			note_mismatch("minor_version", 32'(results_ch.minor_version),
				32'(want.minor_version));
		if (results_ch.major_version !== want.major_version)
			note_mismatch("major_version", 32'(results_ch.major_version),
				32'(want.major_version));
		if (results_ch.pool_count !== want.pool_count)
			note_mismatch("pool_count", 32'(results_ch.pool_count), 32'(want.pool_count));
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || bytes_ch.valid || predicted_results.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : byte_driver
		stim_t            offered;
		cfp_pkg::result_t predicted;
		if (!arst_n) begin
			bytes_ch.valid         <= 1'b0;
			bytes_ch.data_byte     <= '0;
			bytes_ch.start_of_file <= 1'b0;
		end else begin
			if (bytes_ch.valid && bytes_ch.ready) begin
				predicted = classify_byte(offered.data, offered.sof);
				if (offered.typed) begin
					predicted                = '0;
					predicted.section        = offered.sec;
					predicted.echo_byte      = offered.data;
					predicted.pool_done      = offered.done;
					predicted.error_code     = offered.err;
					predicted.minor_version  = offered.minor;
					predicted.major_version  = offered.major;
					predicted.pool_count     = offered.count;
				end
				predicted_results = {predicted_results, predicted};
			end
			if (!bytes_ch.valid || bytes_ch.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					offered = pending_bytes.pop_front();
					bytes_ch.valid         <= 1'b1;
					bytes_ch.data_byte     <= offered.data;
					bytes_ch.start_of_file <= offered.sof;
				end else begin
					bytes_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_checker
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
		end else begin
			if (results_ch.valid && results_ch.ready) begin
				if (predicted_results.size() == 0)
					note_mismatch("unexpected beat, echo_byte", 32'(results_ch.echo_byte),
						32'd0);
				else
					compare_result(predicted_results.pop_front());
			end
			results_ch.ready <= !long_hold && ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// long receiver stall so that the parser backs up into its input
	initial begin : hold_off
		long_hold = 1'b0;
		wait (pressure_go);
		repeat (40) @(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("class_file_constant_pool_parser test failed");
			$finish;
		end
	end

	initial begin : main_sequence
		int base;
		arst_n                 = 1'b0;
		bytes_ch.valid         = 1'b0;
		bytes_ch.data_byte     = '0;
		bytes_ch.start_of_file = 1'b0;
		results_ch.ready       = 1'b0;
		src_idle_pct           = 37;
		sink_idle_pct          = 57;
		pressure_go            = 1'b0;
		beats_queued           = 0;
		mismatch_count         = 0;
		cycle_count            = 0;
		clear_parser();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		foreach (directed_rows[i])
			pending_bytes = {pending_bytes, directed_rows[i]};
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					src_idle_pct  = 37;
					sink_idle_pct = 57;
				end
				1: begin
					src_idle_pct  = 57;
					sink_idle_pct = 37;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
					pressure_go   = 1'b1;
				end
			endcase
			base = beats_queued;
			while (beats_queued - base < RANDOM_PER_PHASE)
				queue_random_file();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("class_file_constant_pool_parser test passed");
		else
			$display("class_file_constant_pool_parser test failed");
		$finish;
	end

endmodule
